// ----- design/mafhs_pkg.sv -----
// Shared types, constants and lookup tables for the MPEG audio header sync core.
package mafhs_pkg;

  // Header pattern constants
  localparam logic [7:0] SyncByte   = 8'hFF;
  localparam logic [3:0] BadBitrate = 4'hF;
  localparam logic [1:0] VerReserved = 2'd1;
  localparam logic [1:0] LayReserved = 2'd0;
  localparam logic [1:0] VerMpeg1    = 2'd3;
  localparam logic [1:0] ModeMono    = 2'd3;

  // Header byte positions
  localparam logic [1:0] PosSync  = 2'd0;
  localparam logic [1:0] PosByte1 = 2'd1;
  localparam logic [1:0] PosByte2 = 2'd2;
  localparam logic [1:0] PosByte3 = 2'd3;

  // Field widths
  localparam int unsigned KbpsW     = 9;
  localparam int unsigned BpsW      = 19;
  localparam int unsigned RateW     = 16;
  localparam int unsigned SpfW      = 11;
  localparam int unsigned LenW      = 12;
  localparam int unsigned DividendW = 26;
  localparam int unsigned DivisorW  = RateW;
  localparam int unsigned DivSteps  = DividendW;
  localparam int unsigned DivCntW   = $clog2(DivSteps);

  localparam logic [BpsW-1:0] KbpsScale = BpsW'(1000);

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RATE,
    S_PROD,
    S_DIV,
    S_OUT
  } state_e;

  // Bitrates in kbit/s: V1 L1, V1 L2, V1 L3, V2 L1, V2 L2/L3
  localparam logic [KbpsW-1:0] KbpsTab [5][16] = '{
    '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
      9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
    '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
    '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
  };

  // Sample rates by version and rate index
  localparam logic [RateW-1:0] RateTab [4][4] = '{
    '{16'd11025, 16'd12000, 16'd8000, 16'd0},
    '{16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd22050, 16'd24000, 16'd16000, 16'd0},
    '{16'd44100, 16'd48000, 16'd32000, 16'd0}
  };

  // Samples per frame by version and raw layer
  localparam logic [SpfW-1:0] SpfTab [4][4] = '{
    '{11'd0, 11'd576, 11'd1152, 11'd384},
    '{11'd0, 11'd0, 11'd0, 11'd0},
    '{11'd0, 11'd576, 11'd1152, 11'd384},
    '{11'd0, 11'd1152, 11'd1152, 11'd384}
  };

  localparam logic [1:0] LayerTab [4] = '{2'd0, 2'd3, 2'd2, 2'd1};
  localparam logic [2:0] SlotTab  [4] = '{3'd0, 3'd1, 3'd1, 3'd4};

  // Check one stream byte against a header position
  function automatic logic byte_ok(input logic [1:0] pos, input logic [7:0] b);
    logic ok;
    unique case (pos)
      PosSync:  ok = (b == SyncByte);
      PosByte1: ok = (b[7:5] == 3'b111) && (b[4:3] != VerReserved) &&
                     (b[2:1] != LayReserved);
      PosByte2: ok = (b[7:4] != BadBitrate);
      default:  ok = 1'b1;
    endcase
    return ok;
  endfunction

  // Bitrate lookup in kbit/s
  function automatic logic [KbpsW-1:0] kbps_lookup(input logic [1:0] ver,
                                                   input logic [1:0] lay,
                                                   input logic [3:0] bri);
    logic [2:0] row;
    logic [KbpsW-1:0] kbps;
    if (ver == VerMpeg1) begin
      row = (lay == 2'd3) ? 3'd0 : (lay == 2'd2) ? 3'd1 : 3'd2;
    end else begin
      row = (lay == 2'd3) ? 3'd3 : 3'd4;
    end
    if (ver == VerReserved || lay == LayReserved) begin
      kbps = '0;
    end else begin
      kbps = KbpsTab[row][bri];
    end
    return kbps;
  endfunction

endpackage

// ----- design/mpeg_audio_frame_header_sync_core.sv -----
// Top level: byte-wise MPEG audio frame header scanner with field decode.
//
// One stream byte per transaction. A byte that does not complete a header
// produces an all-zero result in the cycle after it is taken, so the scanner
// runs at one byte per clock while the output side keeps up. A byte that
// completes a header has its result presented after these steps: the bitrate
// is scaled, the radix-2 divider is started on samples/8 times the bitrate,
// it runs 26 divider steps, its done flag is registered and the output
// register is loaded once the output side does not stall. A zero sample rate
// skips the divider. No new byte is taken meanwhile, so the next byte goes in
// only once the sequencer is idle again and the output side is free.
module mpeg_audio_frame_header_sync_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  stream_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        header_found_o,
  output logic [11:0] frame_length_o,
  output logic [15:0] sample_hz_o,
  output logic [10:0] samples_per_frame_o,
  output logic [18:0] bitrate_bps_o,
  output logic [1:0]  channel_count_o,
  output logic [1:0]  layer_number_o,
  output logic [1:0]  version_code_o,
  output logic        padding_bit_o
);
  import mafhs_pkg::*;

  state_e state_q, state_d;
  logic [1:0] match_q, match_d;
  logic [7:0] hdr1_q, hdr1_d;
  logic [7:0] hdr2_q, hdr2_d;
  logic [1:0] mode_q, mode_d;
  logic [BpsW-1:0] bps_q, bps_d;

  logic            out_valid_q, out_valid_d;
  logic            found_q, found_d;
  logic [LenW-1:0] len_q, len_d;
  logic [RateW-1:0] rate_q, rate_d;
  logic [SpfW-1:0] spf_q, spf_d;
  logic [BpsW-1:0] obps_q, obps_d;
  logic [1:0]      chan_q, chan_d;
  logic [1:0]      layn_q, layn_d;
  logic [1:0]      ver_q, ver_d;
  logic            pad_q, pad_d;

  logic in_accept, out_free;
  logic cur_ok, sync_ok;
  logic [1:0] eff_pos;

  logic [1:0] ver, lay, sri;
  logic [3:0] bri;
  logic       pad;
  logic [RateW-1:0] rate;
  logic [SpfW-1:0]  spf;

  logic                 div_start, div_done;
  logic [DividendW-1:0] dividend, quotient;

  // Decode the held header bytes
  assign ver  = hdr1_q[4:3];
  assign lay  = hdr1_q[2:1];
  assign bri  = hdr2_q[7:4];
  assign sri  = hdr2_q[3:2];
  assign pad  = hdr2_q[1];
  assign rate = RateTab[ver][sri];
  assign spf  = SpfTab[ver][lay];

  // Samples/8 times bitrate feeds the divider
  assign dividend = DividendW'(spf[SpfW-1:3]) * DividendW'(bps_q);

  // Handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Match check: retry a failing byte as a sync byte
  assign cur_ok  = byte_ok(match_q, stream_byte_i);
  assign sync_ok = byte_ok(PosSync, stream_byte_i);
  assign eff_pos = cur_ok ? match_q : PosSync;

  mafhs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (rate),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Sequencer: next state and datapath loads
  always_comb begin
    state_d     = state_q;
    match_d     = match_q;
    hdr1_d      = hdr1_q;
    hdr2_d      = hdr2_q;
    mode_d      = mode_q;
    bps_d       = bps_q;
    div_start   = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    found_d     = found_q;
    len_d       = len_q;
    rate_d      = rate_q;
    spf_d       = spf_q;
    obps_d      = obps_q;
    chan_d      = chan_q;
    layn_d      = layn_q;
    ver_d       = ver_q;
    pad_d       = pad_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if ((!cur_ok && !sync_ok) || eff_pos != PosByte3) begin
            // Non-completing byte: emit an empty result
            out_valid_d = 1'b1;
            found_d     = 1'b0;
            len_d       = '0;
            rate_d      = '0;
            spf_d       = '0;
            obps_d      = '0;
            chan_d      = '0;
            layn_d      = '0;
            ver_d       = '0;
            pad_d       = 1'b0;
            if (!cur_ok && !sync_ok) begin
              match_d = PosSync;
            end else begin
              match_d = eff_pos + 2'd1;
              if (eff_pos == PosByte1) begin
                hdr1_d = stream_byte_i;
              end
              if (eff_pos == PosByte2) begin
                hdr2_d = stream_byte_i;
              end
            end
          end else begin
            // Header complete: hold channel mode and start the length math
            mode_d  = stream_byte_i[7:6];
            match_d = PosSync;
            state_d = S_RATE;
          end
        end
      end
      S_RATE: begin
        bps_d   = BpsW'(kbps_lookup(ver, lay, bri)) * KbpsScale;
        state_d = S_PROD;
      end
      S_PROD: begin
        if (rate == '0) begin
          state_d = S_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          found_d     = 1'b1;
          len_d       = (rate == '0) ? '0 :
                        LenW'(quotient[LenW-1:0] + LenW'(pad ? SlotTab[lay] : 3'd0));
          rate_d      = rate;
          spf_d       = spf;
          obps_d      = bps_q;
          chan_d      = (mode_q == ModeMono) ? 2'd1 : 2'd2;
          layn_d      = LayerTab[lay];
          ver_d       = ver;
          pad_d       = pad;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      match_q     <= PosSync;
      hdr1_q      <= '0;
      hdr2_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      match_q     <= match_d;
      hdr1_q      <= hdr1_d;
      hdr2_q      <= hdr2_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    bps_q  <= bps_d;
    found_q <= found_d;
    len_q  <= len_d;
    rate_q <= rate_d;
    spf_q  <= spf_d;
    obps_q <= obps_d;
    chan_q <= chan_d;
    layn_q <= layn_d;
    ver_q  <= ver_d;
    pad_q  <= pad_d;
  end

  assign out_valid_o         = out_valid_q;
  assign header_found_o      = found_q;
  assign frame_length_o      = len_q;
  assign sample_hz_o         = rate_q;
  assign samples_per_frame_o = spf_q;
  assign bitrate_bps_o       = obps_q;
  assign channel_count_o     = chan_q;
  assign layer_number_o      = layn_q;
  assign version_code_o      = ver_q;
  assign padding_bit_o       = pad_q;

`ifndef ASSERT_OFF
  // Bytes are only taken by an idle sequencer
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> state_q == S_IDLE)
    else $error("byte accepted while the length unit is busy");
  // The match restarts while a header is being measured
  a_match_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> match_q == PosSync)
    else $error("match position not cleared during header processing");
  // Divider finishes only while the sequencer waits for it
  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the wait state");
  // A nonzero frame length needs a known sample rate
  a_len_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_length_o != '0) |-> (header_found_o && sample_hz_o != '0))
    else $error("frame length reported without a sample rate");
`endif

endmodule

// ----- design/mafhs_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
module mafhs_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [mafhs_pkg::DividendW-1:0]    dividend_i,
  input  logic [mafhs_pkg::DivisorW-1:0]     divisor_i,
  output logic                               done_o,
  output logic [mafhs_pkg::DividendW-1:0]    quotient_o
);
  import mafhs_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DivCntW-1:0]    cnt_q, cnt_d;
  logic [DividendW-1:0]  quo_q, quo_d;
  logic [DivisorW-1:0]   rem_q, rem_d;
  logic [DivisorW-1:0]   dvs_q, dvs_d;
  logic [DivisorW:0]     trial;
  logic [DivisorW:0]     diff;
  logic                  fits;

  // Shift in the next dividend bit and try a subtract
  assign trial = {rem_q, quo_q[DividendW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DividendW-2:0], fits};
      rem_d = fits ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

`ifndef ASSERT_OFF
  // A finished division is always preceded by a busy step
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a busy step");
  // A start while idle leaves the unit busy with the step counter at zero
  a_cnt_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_q) |=> (busy_q && cnt_q == '0))
    else $error("divider start did not reset the step count");
  // Done and busy never overlap
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");
`endif

endmodule
